// ===== hw/rtl/vfrc_pkg.sv =====
// Shared types and constants for the volume fade ramp controller.
// Used by vfrc_div and volume_fade_ramp_controller_top; no dependencies.
package vfrc_pkg;

    // Fixed point format of all volumes
    localparam int VOLUME_FRAC_BITS = 15;
    localparam int FULL_SCALE_INT   = 1 << VOLUME_FRAC_BITS;
    localparam int VOL_W            = 16;
    localparam int VOL_MAX_INT      = (1 << VOL_W) - 1;
    localparam int FULL_FIT_INT     = (FULL_SCALE_INT > VOL_MAX_INT) ? VOL_MAX_INT
                                                                      : FULL_SCALE_INT;

    // Elapsed counter and arithmetic widths
    localparam int ELAPSED_W = 17;
    localparam int DUR_W     = 16;
    localparam int PROD_W    = ELAPSED_W + VOL_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam logic [PROD_W-1:0]    FULL_SCALE  = PROD_W'(FULL_SCALE_INT);
    localparam logic [VOL_W-1:0]     FULL_FIT    = VOL_W'(FULL_FIT_INT);
    localparam logic [VOL_W-1:0]     VOL_MAX     = VOL_W'(VOL_MAX_INT);

    // Register reset values
    localparam logic [DUR_W-1:0] DUR_DEFAULT    = 16'd2000;
    localparam logic [VOL_W-1:0] TARGET_DEFAULT = 16'd32768;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PLAY  = 2'd1;
    localparam logic [1:0] OP_PAUSE = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_FADE_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_FADE_DURATION = 2'd1;
    localparam logic [1:0] CFG_TARGET_VOLUME = 2'd2;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DUR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/vfrc_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on vfrc_pkg for widths and the request/response structs.
module vfrc_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  vfrc_pkg::div_req_t req,
    output vfrc_pkg::div_rsp_t rsp
);

    logic [vfrc_pkg::PROD_W-1:0]    dvd_reg;
    logic [vfrc_pkg::PROD_W-1:0]    dvd_next;
    logic [vfrc_pkg::DUR_W-1:0]     rem_reg;
    logic [vfrc_pkg::DUR_W-1:0]     rem_next;
    logic [vfrc_pkg::DUR_W-1:0]     dsr_reg;
    logic [vfrc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [vfrc_pkg::DUR_W:0]       trial;
    logic                           q_bit;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[vfrc_pkg::PROD_W-1]};
        q_bit    = (trial >= {1'b0, dsr_reg});
        rem_next = q_bit ? vfrc_pkg::DUR_W'(trial - {1'b0, dsr_reg})
                         : trial[vfrc_pkg::DUR_W-1:0];
        dvd_next = {dvd_reg[vfrc_pkg::PROD_W-2:0], q_bit};
    end

    // Control: load on start, step while busy, pulse done after the last step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == vfrc_pkg::DIV_CNT_W'(vfrc_pkg::PROD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: dividend register turns into the quotient
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

// ===== hw/rtl/volume_fade_ramp_controller_top.sv =====
// Volume fade ramp controller: one result item per input item.
// Commands, plain ticks, ramp-end ticks and fade-out ticks that reach zero: result
// registered in the cycle after accept. Other ramp ticks run a multiply, 33 divider steps
// and an output load through the serial divider; no new item is taken until that is done.
// Asynchronous active-low reset loads register defaults and full-scale volume.
// Depends on vfrc_pkg and vfrc_div.
module volume_fade_ramp_controller_top
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] elapse_ms
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] volume, [16] start_play, [17] stop_stream,
                                   // [18] rewind_stream, [19] fading, [23:20] zero
    output logic [0:0]  m_tuser    // [0] volume_written
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    // configuration
    logic                            fade_enable_reg;
    logic [vfrc_pkg::DUR_W-1:0]      fade_duration_reg;
    logic [vfrc_pkg::VOL_W-1:0]      target_volume_reg;

    // controller state
    logic [1:0]                      state_reg, state_next;
    logic [1:0]                      pending_reg, pending_next;
    logic [vfrc_pkg::ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic [vfrc_pkg::VOL_W-1:0]      fade_start_reg, fade_start_next;
    logic [vfrc_pkg::VOL_W-1:0]      cur_vol_reg, cur_vol_next;
    logic                            ramp_up_reg, ramp_up_next;
    logic [vfrc_pkg::ELAPSED_W-1:0]  mul_a_reg, mul_a_next;
    logic [vfrc_pkg::VOL_W-1:0]      mul_b_reg, mul_b_next;

    // output slot
    logic                            out_valid_reg, out_valid_next;
    logic [vfrc_pkg::VOL_W-1:0]      out_vol_reg, out_vol_next;
    logic                            out_wr_reg, out_wr_next;
    logic                            out_play_reg, out_play_next;
    logic                            out_stop_reg, out_stop_next;
    logic                            out_rew_reg, out_rew_next;
    logic                            out_fading_reg, out_fading_next;

    // working signals
    logic                            in_accept;
    logic                            go_mul;
    logic [vfrc_pkg::DUR_W-1:0]      dur;
    logic [vfrc_pkg::ELAPSED_W:0]    elapsed_sum;
    logic [vfrc_pkg::ELAPSED_W-1:0]  elapsed_adv;
    logic                            in_window;
    logic [vfrc_pkg::VOL_W-1:0]      start_vol;
    logic [vfrc_pkg::PROD_W-1:0]     q_clip;
    logic [vfrc_pkg::VOL_W-1:0]      vol_fit;

    vfrc_pkg::div_req_t              div_req;
    vfrc_pkg::div_rsp_t              div_rsp;

    vfrc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0000, out_fading_reg, out_rew_reg, out_stop_reg,
                        out_play_reg, out_vol_reg};
    assign m_tuser   = out_wr_reg;

    // Effective duration, elapsed advance and captured start volume
    always_comb
    begin
        dur         = (fade_duration_reg == '0) ? vfrc_pkg::DUR_W'(1) : fade_duration_reg;
        elapsed_sum = {1'b0, elapsed_reg} + (vfrc_pkg::ELAPSED_W + 1)'(s_tdata);
        elapsed_adv = (elapsed_sum > {1'b0, vfrc_pkg::ELAPSED_MAX})
                    ? vfrc_pkg::ELAPSED_MAX : elapsed_sum[vfrc_pkg::ELAPSED_W-1:0];
        in_window   = (elapsed_reg <= vfrc_pkg::ELAPSED_W'(dur));
        start_vol   = (elapsed_reg == '0) ? cur_vol_reg : fade_start_reg;
    end

    // Clip a ramp-up quotient at full scale and fit the quotient to 16 bits
    always_comb
    begin
        q_clip  = (ramp_up_reg && (div_rsp.quotient > vfrc_pkg::FULL_SCALE))
                ? vfrc_pkg::FULL_SCALE : div_rsp.quotient;
        vol_fit = (q_clip > vfrc_pkg::PROD_W'(vfrc_pkg::VOL_MAX))
                ? vfrc_pkg::VOL_MAX : q_clip[vfrc_pkg::VOL_W-1:0];
    end

    // Sequencer and item decode
    always_comb
    begin
        state_next      = state_reg;
        pending_next    = pending_reg;
        elapsed_next    = elapsed_reg;
        fade_start_next = fade_start_reg;
        cur_vol_next    = cur_vol_reg;
        ramp_up_next    = ramp_up_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        out_vol_next    = out_vol_reg;
        out_wr_next     = out_wr_reg;
        out_play_next   = out_play_reg;
        out_stop_next   = out_stop_reg;
        out_rew_next    = out_rew_reg;
        out_fading_next = out_fading_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        go_mul          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = vfrc_pkg::PROD_W'(mul_a_reg) * vfrc_pkg::PROD_W'(mul_b_reg);
        div_req.divisor  = dur;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    out_vol_next  = '0;
                    out_wr_next   = 1'b0;
                    out_play_next = 1'b0;
                    out_stop_next = 1'b0;
                    out_rew_next  = 1'b0;
                    case (s_tuser)
                        vfrc_pkg::OP_TICK:
                        begin
                            if (pending_reg != vfrc_pkg::OP_TICK)
                            begin
                                if (fade_enable_reg)
                                begin
                                    if (pending_reg == vfrc_pkg::OP_PLAY)
                                    begin
                                        if (in_window)
                                        begin
                                            // Ramp up: elapsed * target / dur
                                            out_play_next = (elapsed_reg == '0);
                                            out_wr_next   = 1'b1;
                                            elapsed_next  = elapsed_adv;
                                            mul_a_next    = elapsed_adv;
                                            mul_b_next    = target_volume_reg;
                                            ramp_up_next  = 1'b1;
                                            go_mul        = 1'b1;
                                        end
                                        else
                                        begin
                                            elapsed_next = '0;
                                            pending_next = vfrc_pkg::OP_TICK;
                                        end
                                    end
                                    else
                                    begin
                                        fade_start_next = start_vol;
                                        if (in_window)
                                        begin
                                            elapsed_next = elapsed_adv;
                                            out_wr_next  = 1'b1;
                                            if (elapsed_adv < vfrc_pkg::ELAPSED_W'(dur))
                                            begin
                                                // Ramp down: start * (dur - elapsed) / dur
                                                mul_a_next   = vfrc_pkg::ELAPSED_W'(
                                                    dur - elapsed_adv[vfrc_pkg::DUR_W-1:0]);
                                                mul_b_next   = start_vol;
                                                ramp_up_next = 1'b0;
                                                go_mul       = 1'b1;
                                            end
                                            else
                                            begin
                                                cur_vol_next = '0;
                                            end
                                        end
                                        else
                                        begin
                                            // Ramp over: halt the stream
                                            out_stop_next = 1'b1;
                                            out_rew_next  = (pending_reg == vfrc_pkg::OP_STOP);
                                            elapsed_next  = '0;
                                            pending_next  = vfrc_pkg::OP_TICK;
                                        end
                                    end
                                end
                                else
                                begin
                                    // Fading off: reissue the raw action
                                    out_play_next = (pending_reg == vfrc_pkg::OP_PLAY);
                                    out_stop_next = (pending_reg != vfrc_pkg::OP_PLAY);
                                    out_rew_next  = (pending_reg == vfrc_pkg::OP_STOP);
                                end
                            end
                        end
                        default:
                        begin
                            pending_next = s_tuser;
                            elapsed_next = '0;
                        end
                    endcase
                    out_fading_next = (pending_next != vfrc_pkg::OP_TICK);
                    if (go_mul)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                // Multiply straight into the divider load
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    out_vol_next   = vol_fit;
                    cur_vol_next   = vol_fit;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_enable_reg   <= 1'b1;
            fade_duration_reg <= vfrc_pkg::DUR_DEFAULT;
            target_volume_reg <= vfrc_pkg::TARGET_DEFAULT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vfrc_pkg::CFG_FADE_ENABLE:   fade_enable_reg   <= cfg_data[0];
                vfrc_pkg::CFG_FADE_DURATION: fade_duration_reg <= cfg_data;
                vfrc_pkg::CFG_TARGET_VOLUME: target_volume_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Control and fade state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pending_reg    <= vfrc_pkg::OP_TICK;
            elapsed_reg    <= '0;
            fade_start_reg <= vfrc_pkg::FULL_FIT;
            cur_vol_reg    <= vfrc_pkg::FULL_FIT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pending_reg    <= pending_next;
            elapsed_reg    <= elapsed_next;
            fade_start_reg <= fade_start_next;
            cur_vol_reg    <= cur_vol_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Operands and result payload
    always_ff @(posedge clk)
    begin
        ramp_up_reg    <= ramp_up_next;
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        out_vol_reg    <= out_vol_next;
        out_wr_reg     <= out_wr_next;
        out_play_reg   <= out_play_next;
        out_stop_reg   <= out_stop_next;
        out_rew_reg    <= out_rew_next;
        out_fading_reg <= out_fading_next;
    end

    // The divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider done outside the divide wait");

    // The output slot is empty while a ramp item is computed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_DIV) |-> !out_valid_reg)
        else $error("result slot occupied during a ramp computation");

    // A held result reports the pending command that is in effect
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_fading_reg == (pending_reg != vfrc_pkg::OP_TICK)))
        else $error("fading flag disagrees with the pending command");

    // A written volume never exceeds full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_wr_reg) |-> (out_vol_reg <= vfrc_pkg::FULL_FIT))
        else $error("volume above full scale");

endmodule
